// File: rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: operation kinds,
// status codes and the stored value type.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

   typedef logic [2:0]        kind_type;
   typedef logic [1:0]        status_type;
   typedef logic signed [31:0] value_type;

   // operation kinds
   localparam kind_type KIND_PUSH_FRONT = 3'd0;
   localparam kind_type KIND_PUSH_BACK  = 3'd1;
   localparam kind_type KIND_INSERT     = 3'd2;
   localparam kind_type KIND_DELETE     = 3'd3;
   localparam kind_type KIND_POP_FRONT  = 3'd4;
   localparam kind_type KIND_POP_BACK   = 3'd5;

   // result status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;
   localparam status_type STATUS_FULL  = 2'd3;

endpackage

`default_nettype wire

// File: rtl/ole_store.sv
// ----------------------------------------------------------------------------
// ole_store
// Entry memory of the ordered list engine: one write port and one read
// port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_store #(
   parameter int CAPACITY = 64
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(CAPACITY)-1:0]   wr_addr,
   input  wire ole_pkg::value_type            wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
   output ole_pkg::value_type                 rd_data
);

   ole_pkg::value_type mem [CAPACITY];
   ole_pkg::value_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded double-ended list of signed 32-bit values kept in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one operation word (kind, item_value, position);
//   rsp_ channel returns one result word per operation (status, removed,
//   removed_value, entry_count). Both channels use valid/ready.
//   Entries live in a circular buffer in a single-port-write, single-port-read
//   memory with a head pointer, so the list ends move in one access.
//   Push, unused kinds and errors finish in the decode state; pop front/back
//   waits in S_POP_WAIT for the registered read data. Insert at position p
//   moves the count-p entries from p up one slot, then writes the new value;
//   delete value reads and compares entries from the front, then moves the
//   later entries down one slot. Each move is one memory read plus one write.
//   One operation is worked at a time; the next word is taken as soon as the
//   engine is back idle, even while an earlier result waits on rsp_ready.
//   A stalled receiver holds the result register and the engine waits before
//   loading the next result.
//   Reset empties the list (count and head to zero); memory content is not
//   cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine #(
   parameter int CAPACITY = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ole_pkg::kind_type     req_kind,
   input  wire ole_pkg::value_type    req_item_value,
   input  wire logic [6:0]            req_position,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ole_pkg::status_type        rsp_status,
   output logic                       rsp_removed,
   output ole_pkg::value_type         rsp_removed_value,
   output logic [6:0]                 rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW : 7;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_POP_WAIT = 4'd2;
   localparam logic [3:0] S_INS_RD   = 4'd3;
   localparam logic [3:0] S_INS_WR   = 4'd4;
   localparam logic [3:0] S_INS_PUT  = 4'd5;
   localparam logic [3:0] S_DEL_RD   = 4'd6;
   localparam logic [3:0] S_DEL_CMP  = 4'd7;
   localparam logic [3:0] S_SH_RD    = 4'd8;
   localparam logic [3:0] S_SH_WR    = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   // logical slot to memory address in the circular buffer
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
      logic [AW:0] s;
      s = (AW+1)'(h) + (AW+1)'(i);
      if (s >= (AW+1)'(CAPACITY)) begin
         s = s - (AW+1)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        idx_ff, idx_in;

   ole_pkg::kind_type    op_kind_ff, op_kind_in;
   ole_pkg::value_type   op_value_ff, op_value_in;
   logic [6:0]           op_pos_ff, op_pos_in;

   ole_pkg::status_type  res_status_ff, res_status_in;
   logic                 res_removed_ff, res_removed_in;
   ole_pkg::value_type   res_value_ff, res_value_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   ole_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                 rsp_removed_ff, rsp_removed_in;
   ole_pkg::value_type   rsp_value_ff, rsp_value_in;
   logic [6:0]           rsp_count_ff, rsp_count_in;

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   ole_pkg::value_type   mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   ole_pkg::value_type   mem_rd_data;

   logic                 full;
   logic                 empty;
   logic [CW-1:0]        last_idx;
   logic [CW-1:0]        pos_c;
   logic                 pos_bad;
   logic                 req_take;

   ole_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // list status helpers
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign last_idx = count_ff - CW'(1);
   assign pos_c    = CW'(op_pos_ff);
   assign pos_bad  = (PW'(op_pos_ff) > PW'(count_ff));

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      idx_in         = idx_ff;
      op_kind_in     = op_kind_ff;
      op_value_in    = op_value_ff;
      op_pos_in      = op_pos_ff;
      res_status_in  = res_status_ff;
      res_removed_in = res_removed_ff;
      res_value_in   = res_value_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = '0;
      mem_wr_data    = op_value_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = '0;

      // receiver takes the pending result word
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_kind_in     = req_kind;
               op_value_in    = req_item_value;
               op_pos_in      = req_position;
               res_status_in  = ole_pkg::STATUS_OK;
               res_removed_in = 1'b0;
               res_value_in   = '0;
               state_in       = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_DONE;
            case (op_kind_ff)
               ole_pkg::KIND_PUSH_FRONT: begin
                  if (full) begin
                     res_status_in = ole_pkg::STATUS_FULL;
                  end else begin
                     head_in     = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
                     count_in    = count_ff + CW'(1);
                  end
               end
               ole_pkg::KIND_PUSH_BACK: begin
                  if (full) begin
                     res_status_in = ole_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = phys(head_ff, count_ff);
                     count_in    = count_ff + CW'(1);
                  end
               end
               ole_pkg::KIND_INSERT: begin
                  if (pos_bad) begin
                     res_status_in = ole_pkg::STATUS_RANGE;
                  end else if (full) begin
                     res_status_in = ole_pkg::STATUS_FULL;
                  end else if (pos_c == count_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = phys(head_ff, count_ff);
                     count_in    = count_ff + CW'(1);
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_INS_RD;
                  end
               end
               ole_pkg::KIND_DELETE: begin
                  if (empty) begin
                     res_status_in = ole_pkg::STATUS_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = S_DEL_RD;
                  end
               end
               ole_pkg::KIND_POP_FRONT: begin
                  if (empty) begin
                     res_status_in = ole_pkg::STATUS_EMPTY;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     state_in    = S_POP_WAIT;
                  end
               end
               ole_pkg::KIND_POP_BACK: begin
                  if (empty) begin
                     res_status_in = ole_pkg::STATUS_EMPTY;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = phys(head_ff, last_idx);
                     state_in    = S_POP_WAIT;
                  end
               end
               default: begin
               end
            endcase
         end

         // popped word is back from memory
         S_POP_WAIT: begin
            res_removed_in = 1'b1;
            res_value_in   = mem_rd_data;
            count_in       = last_idx;
            if (op_kind_ff == ole_pkg::KIND_POP_FRONT) begin
               head_in = phys(head_ff, CW'(1));
            end
            state_in = S_DONE;
         end

         // insert: move entries up one slot, from the back toward position
         S_INS_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = phys(head_ff, idx_ff - CW'(1));
            state_in    = S_INS_WR;
         end

         S_INS_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, idx_ff);
            mem_wr_data = mem_rd_data;
            idx_in      = idx_ff - CW'(1);
            state_in    = ((idx_ff - CW'(1)) == pos_c) ? S_INS_PUT : S_INS_RD;
         end

         S_INS_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, pos_c);
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end

         // delete: scan from the front for the first equal entry
         S_DEL_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = phys(head_ff, idx_ff);
            state_in    = S_DEL_CMP;
         end

         S_DEL_CMP: begin
            if (mem_rd_data == op_value_ff) begin
               res_removed_in = 1'b1;
               res_value_in   = mem_rd_data;
               if (idx_ff == last_idx) begin
                  count_in = last_idx;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SH_RD;
               end
            end else if (idx_ff == last_idx) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_DEL_RD;
            end
         end

         // delete: close the gap by moving later entries down one slot
         S_SH_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = phys(head_ff, idx_ff + CW'(1));
            state_in    = S_SH_WR;
         end

         S_SH_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, idx_ff);
            mem_wr_data = mem_rd_data;
            if ((idx_ff + CW'(1)) == last_idx) begin
               count_in = last_idx;
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SH_RD;
            end
         end

         // load the result word once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_removed_in = res_removed_ff;
               rsp_value_in   = res_value_ff;
               rsp_count_in   = 7'(count_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_kind_ff     <= op_kind_in;
      op_value_ff    <= op_value_in;
      op_pos_ff      <= op_pos_in;
      res_status_ff  <= res_status_in;
      res_removed_ff <= res_removed_in;
      res_value_ff   <= res_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed       = rsp_removed_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

`default_nettype wire
